### design/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
// No dependencies; every other design file refers to this package by scoped names.

package sfr_pkg;

  // Default bounds on pattern and replacement length, in bytes.
  localparam int MAX_PATTERN_BYTES     = 8;
  localparam int MAX_REPLACEMENT_BYTES = 8;

  // Byte slots carried by one job between the front and the back.
  localparam int ENTRY_BYTES = 8;
  // Width of byte counts and length registers.
  localparam int COUNT_W     = 4;
  // Depth of the job queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_end;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stream_end;
    logic       run_last;
  } result_t;

  // One unit of output work: emit the first count bytes, oldest in the lowest
  // byte. A job with fin set closes the stream; with count zero it is a bare
  // end marker.
  typedef struct packed {
    logic [ENTRY_BYTES*8-1:0] bytes;
    logic [COUNT_W-1:0]       count;
    logic                     fin;
  } job_t;

endpackage

### design/sfr_front.sv
// Front end of the find-and-replace block: configuration registers, pending bytes
// and the per-item classification into output jobs. Depends on sfr_pkg.

module sfr_front #(
  parameter int PAT_MAX = sfr_pkg::MAX_PATTERN_BYTES,
  parameter int REP_MAX = sfr_pkg::MAX_REPLACEMENT_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              push,
  input  sfr_pkg::item_t                    item,
  input  logic                              queue_full,
  output logic                              job_push,
  output sfr_pkg::job_t                     job
);

  localparam int CW = sfr_pkg::COUNT_W;
  localparam int EB = sfr_pkg::ENTRY_BYTES;

  logic [63:0]   pattern_bytes;
  logic [CW-1:0] pattern_length;
  logic [63:0]   replacement_bytes;
  logic [CW-1:0] replacement_length;

  logic [7:0]    pend [PAT_MAX];
  logic [7:0]    pend_next [PAT_MAX];
  logic [CW-1:0] pend_count;
  logic [CW-1:0] pend_count_next;

  logic [CW-1:0] plen;
  logic [CW-1:0] rlen;
  logic [CW-1:0] cfg_plen;
  logic [7:0]    ext [2*EB];
  logic [EB*8-1:0] ext_packed;
  logic [CW-1:0] grown;
  logic [EB:0]   keep_ok;
  logic [CW-1:0] shift;
  logic [CW-1:0] remain;
  logic          match;
  logic          accept;

  function automatic logic [CW-1:0] clamp_plen(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    r = v;
    if (r == '0) r = CW'(1);
    if (r > CW'(PAT_MAX)) r = CW'(PAT_MAX);
    return r;
  endfunction

  assign plen     = clamp_plen(pattern_length);
  assign cfg_plen = clamp_plen(cfg_data[CW-1:0]);
  assign rlen     = (replacement_length > CW'(REP_MAX)) ? CW'(REP_MAX) : replacement_length;
  assign accept   = push && !queue_full;
  assign grown    = pend_count + CW'(1);

  // Pending bytes with the incoming byte appended at the end.
  always_comb begin
    for (int i = 0; i < 2*EB; i++) begin
      ext[i] = '0;
    end
    for (int i = 0; i < PAT_MAX; i++) begin
      if (CW'(i) < pend_count) begin
        ext[i] = pend[i];
      end
    end
    ext[pend_count] = item.data_byte;
    for (int i = 0; i < EB; i++) begin
      ext_packed[i*8 +: 8] = ext[i];
    end
  end

  // keep_ok[k]: dropping the first k bytes leaves a prefix of the pattern.
  always_comb begin
    for (int k = 0; k <= EB; k++) begin
      keep_ok[k] = 1'b1;
      for (int j = 0; j < EB; j++) begin
        if (CW'(k + j) < grown && ext[k + j] != pattern_bytes[j*8 +: 8]) begin
          keep_ok[k] = 1'b0;
        end
      end
    end
    shift = CW'(EB);
    for (int k = EB; k >= 0; k--) begin
      if (keep_ok[k]) shift = CW'(k);
    end
  end

  assign remain = grown - shift;
  assign match  = (remain == plen);

  always_comb begin
    job_push        = 1'b0;
    job             = '0;
    pend_count_next = pend_count;
    for (int i = 0; i < PAT_MAX; i++) begin
      pend_next[i] = pend[i];
    end
    if (accept) begin
      if (item.is_end) begin
        job.bytes       = ext_packed;
        job.count       = pend_count;
        job.fin         = 1'b1;
        job_push        = 1'b1;
        pend_count_next = '0;
      end else begin
        for (int i = 0; i < PAT_MAX; i++) begin
          pend_next[i] = ext[shift + CW'(i)];
        end
        if (match) begin
          job.bytes       = replacement_bytes;
          job.count       = rlen;
          pend_count_next = '0;
        end else begin
          job.bytes       = ext_packed;
          job.count       = shift;
          pend_count_next = remain;
        end
        job_push = (job.count != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PAT_MAX; i++) begin
      pend[i] <= pend_next[i];
    end
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= CW'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
      pend_count         <= '0;
    end else begin
      pend_count <= pend_count_next;
      if (cfg_write) begin
        case (sfr_pkg::cfg_reg_t'(cfg_index))
          sfr_pkg::REG_PATTERN_BYTES: begin
            pattern_bytes <= cfg_data[63:0];
          end
          sfr_pkg::REG_PATTERN_LENGTH: begin
            pattern_length <= cfg_data[CW-1:0];
            if (pend_count >= cfg_plen) pend_count <= '0;
          end
          sfr_pkg::REG_REPLACEMENT_BYTES: begin
            replacement_bytes <= cfg_data[63:0];
          end
          sfr_pkg::REG_REPLACEMENT_LENGTH: begin
            replacement_length <= cfg_data[CW-1:0];
          end
          default: begin
            pattern_bytes <= pattern_bytes;
          end
        endcase
      end
    end
  end

endmodule

### design/sfr_queue.sv
// Short job queue that decouples the front end from the output serializer.
// Depends on sfr_pkg for the job type and the depth.

module sfr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  sfr_pkg::job_t wr_job,
  input  logic          rd,
  output sfr_pkg::job_t head,
  output logic          empty,
  output logic          full
);

  localparam int DEPTH = sfr_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  sfr_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign empty = (fill == '0);
  assign full  = (fill == NW'(DEPTH));
  assign head  = slots[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_job;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= bump(wr_ptr);
      if (do_rd) rd_ptr <= bump(rd_ptr);
      if (do_wr && !do_rd) begin
        fill <= fill + NW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

### design/sfr_back.sv
// Back end of the find-and-replace block: turns queued jobs into result items,
// one per cycle when popped, via an output register. Depends on sfr_pkg.

module sfr_back (
  input  logic             clk,
  input  logic             rst,
  input  sfr_pkg::job_t    head,
  input  logic             queue_empty,
  output logic             queue_pop,
  output sfr_pkg::result_t result,
  output logic             empty,
  input  logic             pop
);

  localparam int CW = sfr_pkg::COUNT_W;
  localparam int IW = $clog2(sfr_pkg::ENTRY_BYTES);

  logic             out_valid;
  sfr_pkg::result_t out_reg;
  sfr_pkg::result_t out_next;
  logic [IW-1:0]    idx;
  logic             load;
  logic             last;

  assign load      = !queue_empty && (!out_valid || pop);
  assign last      = (head.count == '0) || ({1'b0, idx} == head.count - CW'(1));
  assign queue_pop = load && last;
  assign empty     = !out_valid;
  assign result    = out_reg;

  always_comb begin
    out_next.byte_valid = (head.count != '0);
    out_next.out_byte   = out_next.byte_valid ? head.bytes[{idx, 3'b000} +: 8] : 8'd0;
    out_next.run_last   = last;
    out_next.stream_end = last && head.fin;
  end

  always_ff @(posedge clk) begin
    if (load) out_reg <= out_next;
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? '0 : idx + IW'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/stream_find_replace.sv
// Top level of the streaming find-and-replace block.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.

// The block rewrites a byte stream, replacing every leftmost, non-overlapping
// occurrence of the configured pattern with the configured replacement, which
// may be empty. Bytes enter through a queue-like port (push/full) and results
// leave through another (empty/pop). An item is either a data byte or an end
// marker; the end marker flushes any bytes still held as a partial match and
// flags the last result of the stream, or produces a single bare marker with
// byte_valid low when nothing is held. The front end takes one item per clock
// while its two-entry job queue has room and decides in that same cycle what
// the item releases: held bytes that can no longer start a match, the whole
// replacement, or the flush. The back end sends those bytes out one per clock
// while results are popped; an item yields at most eight results. An item that
// only extends a partial match, or completes one with an empty replacement,
// produces nothing at the output. Write the configuration registers only while
// the block is idle; lengths outside their range are clamped, and shortening
// the pattern to no more than the number of held bytes discards them.

module stream_find_replace #(
  parameter int MAX_PATTERN_BYTES     = sfr_pkg::MAX_PATTERN_BYTES,
  parameter int MAX_REPLACEMENT_BYTES = sfr_pkg::MAX_REPLACEMENT_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_write,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input items.
  input  logic                            push,
  output logic                            full,
  input  sfr_pkg::item_t                  item,
  // Result items.
  output logic                            empty,
  input  logic                            pop,
  output sfr_pkg::result_t                result
);

  sfr_pkg::job_t new_job;
  sfr_pkg::job_t head_job;
  logic          job_push;
  logic          job_pop;
  logic          queue_empty;
  logic          queue_full;

  // The input side stalls only when the job queue is full.
  assign full = queue_full;

  sfr_front #(
    .PAT_MAX (MAX_PATTERN_BYTES),
    .REP_MAX (MAX_REPLACEMENT_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .item       (item),
    .queue_full (queue_full),
    .job_push   (job_push),
    .job        (new_job)
  );

  sfr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_job (new_job),
    .rd     (job_pop),
    .head   (head_job),
    .empty  (queue_empty),
    .full   (queue_full)
  );

  sfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_job),
    .queue_empty (queue_empty),
    .queue_pop   (job_pop),
    .result      (result),
    .empty       (empty),
    .pop         (pop)
  );

endmodule
